### hdl/ukc_pkg.sv
// Package for the UTF-8 kana converter.
// Holds the code point constants, the grouping step type and the conversion functions.
// No dependencies.
package ukc_pkg;

    localparam logic [15:0] KANA_SHIFT = 16'd96;
    localparam logic [15:0] HIRA_LOW   = 16'h3040;
    localparam logic [15:0] HIRA_HIGH  = 16'h309F;
    localparam logic [15:0] KATA_LOW   = 16'h30A0;
    localparam logic [15:0] KATA_HIGH  = 16'h30FF;

    localparam logic DIR_HIRA_TO_KATA = 1'b0;
    localparam logic DIR_KATA_TO_HIRA = 1'b1;

    typedef struct packed {
        logic        emit;
        logic [31:0] char_bytes;
        logic [2:0]  byte_count;
        logic [23:0] pend_next;
        logic [2:0]  exp_next;
        logic [2:0]  rcv_next;
    } ukc_step_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        priority if (b < 8'hC0)
        begin
            len = 3'd1;
        end
        else if (b < 8'hE0)
        begin
            len = 3'd2;
        end
        else if (b < 8'hF0)
        begin
            len = 3'd3;
        end
        else if (b < 8'hF8)
        begin
            len = 3'd4;
        end
        else
        begin
            len = 3'd1;
        end
        return len;
    endfunction

    // Converts a right-aligned three-byte group; anything else is returned as is.
    function automatic logic [23:0] kana_convert(input logic [23:0] acc, input logic dir);
        logic [15:0] cp;
        logic [15:0] cp_new;
        logic        hit;
        cp = {acc[19:16], acc[13:8], acc[5:0]};
        if (dir == DIR_HIRA_TO_KATA)
        begin
            hit    = (cp >= HIRA_LOW) && (cp <= HIRA_HIGH);
            cp_new = cp + KANA_SHIFT;
        end
        else
        begin
            hit    = (cp >= KATA_LOW) && (cp <= KATA_HIGH);
            cp_new = cp - KANA_SHIFT;
        end
        if ((acc & 24'hF0C0C0) != 24'hE08080)
        begin
            hit = 1'b0;
        end
        return hit ? {4'hE, cp_new[15:12], 2'b10, cp_new[11:6], 2'b10, cp_new[5:0]} : acc;
    endfunction

endpackage

### hdl/ukc_in_if.sv
// Input byte channel of the UTF-8 kana converter.
// Carries valid, ready and one string byte per transaction; no dependencies.
interface ukc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       string_end;

    modport source (output valid, output data_byte, output string_end, input ready);
    modport sink   (input valid, input data_byte, input string_end, output ready);
endinterface

### hdl/ukc_out_if.sv
// Output character channel of the UTF-8 kana converter.
// Carries valid, ready and one packed character per transaction; no dependencies.
interface ukc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] char_bytes;
    logic [2:0]  byte_count;
    logic        end_of_string;

    modport source (output valid, output char_bytes, output byte_count,
                    output end_of_string, input ready);
    modport sink   (input valid, input char_bytes, input byte_count,
                    input end_of_string, output ready);
endinterface

### hdl/ukc_group.sv
// Character grouping and conversion logic for one byte, purely combinational.
// Depends on ukc_pkg.
module ukc_group (
    input  logic [7:0]       data_byte,
    input  logic             string_end,
    input  logic             direction,
    input  logic [23:0]      pend,
    input  logic [2:0]       exp_len,
    input  logic [2:0]       rcv,
    output ukc_pkg::ukc_step_t step
);
    import ukc_pkg::*;

    logic        open_char;
    logic [2:0]  eff_len;
    logic [23:0] eff_pend;
    logic [2:0]  count;
    logic [31:0] acc;
    logic [31:0] grp;
    logic        complete;

    always_comb
    begin
        open_char = (exp_len != 3'd0);
        eff_len   = open_char ? exp_len : lead_length(data_byte);
        eff_pend  = open_char ? pend : 24'd0;
        count     = (open_char ? rcv : 3'd0) + 3'd1;
        acc       = {eff_pend, data_byte};
        complete  = (count >= eff_len);

        grp = acc;
        if (complete && count == 3'd3)
        begin
            grp = {8'd0, kana_convert(acc[23:0], direction)};
        end

        unique case (count)
            3'd1:    step.char_bytes = {grp[7:0], 24'd0};
            3'd2:    step.char_bytes = {grp[15:0], 16'd0};
            3'd3:    step.char_bytes = {grp[23:0], 8'd0};
            default: step.char_bytes = grp;
        endcase

        step.emit       = complete || string_end;
        step.byte_count = count;
        if (step.emit)
        begin
            step.pend_next = 24'd0;
            step.exp_next  = 3'd0;
            step.rcv_next  = 3'd0;
        end
        else
        begin
            step.pend_next = acc[23:0];
            step.exp_next  = eff_len;
            step.rcv_next  = count;
        end
    end

endmodule

### hdl/utf8_kana_converter.sv
// Top level of the UTF-8 kana converter: input register, grouping logic and result register.
// Depends on ukc_pkg, ukc_in_if, ukc_out_if and ukc_group.
//
// Channel     Direction  Payload                                  Handshake
// byte_in     in         data_byte[7:0], string_end               valid/ready
// char_out    out        char_bytes[31:0], byte_count, end_of_str valid/ready
// cfg         in         cfg_wdata (direction)                    cfg_we, no wait
//
// One byte per cycle is taken unless the result stalls; it moves from input to result register.
// Throughput is set by the single grouping stage between the input and result registers.
// Reset clears the open character, the direction and both valid bits.
// A stalled result holds the input stage; the input stage still accepts when it moves on.
module utf8_kana_converter (
    input  logic     clk,
    input  logic     rst_n,
    ukc_in_if.sink   byte_in,
    ukc_out_if.source char_out,
    input  logic     cfg_we,
    input  logic     cfg_wdata
);
    import ukc_pkg::*;

    logic        dir_reg;
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic [23:0] pend_reg;
    logic [2:0]  exp_reg;
    logic [2:0]  rcv_reg;
    logic        out_valid_reg;
    logic [31:0] out_bytes_reg;
    logic [2:0]  out_count_reg;
    logic        out_end_reg;

    logic        out_free;
    logic        s1_fire;
    ukc_step_t   step;

    assign out_free     = !out_valid_reg || char_out.ready;
    assign s1_fire      = s1_valid_reg && out_free;
    assign byte_in.ready = !s1_valid_reg || out_free;

    ukc_group u_group (
        .data_byte  (s1_byte_reg),
        .string_end (s1_last_reg),
        .direction  (dir_reg),
        .pend       (pend_reg),
        .exp_len    (exp_reg),
        .rcv        (rcv_reg),
        .step       (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= DIR_HIRA_TO_KATA;
            s1_valid_reg  <= 1'b0;
            pend_reg      <= 24'd0;
            exp_reg       <= 3'd0;
            rcv_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dir_reg <= cfg_wdata;
            end
            if (byte_in.ready)
            begin
                s1_valid_reg <= byte_in.valid;
            end
            if (s1_fire)
            begin
                pend_reg <= step.pend_next;
                exp_reg  <= step.exp_next;
                rcv_reg  <= step.rcv_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg && step.emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.ready && byte_in.valid)
        begin
            s1_byte_reg <= byte_in.data_byte;
            s1_last_reg <= byte_in.string_end;
        end
        if (s1_fire && step.emit)
        begin
            out_bytes_reg <= step.char_bytes;
            out_count_reg <= step.byte_count;
            out_end_reg   <= s1_last_reg;
        end
    end

    assign char_out.valid         = out_valid_reg;
    assign char_out.char_bytes    = out_bytes_reg;
    assign char_out.byte_count    = out_count_reg;
    assign char_out.end_of_string = out_end_reg;

endmodule

### verif/tb_utf8_kana_converter.sv
// Self-checking testbench for utf8_kana_converter: UTF-8 byte strings in both directions.
// A predictor groups and converts each accepted byte; results are checked in order.
// Depends on ukc_pkg, ukc_in_if, ukc_out_if and the block itself.
module tb_utf8_kana_converter;
    import ukc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_BYTES  = 500;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } str_byte_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  count;
        logic        eos;
    } kana_char_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;

    ukc_in_if  in_ch ();
    ukc_out_if out_ch ();

    utf8_kana_converter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (in_ch),
        .char_out (out_ch),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    str_byte_t  tx_bytes[$];
    kana_char_t kana_expected[$];

    logic        dir_now = DIR_HIRA_TO_KATA;
    logic [23:0] open_acc = '0;
    logic [2:0]  open_len = '0;
    logic [2:0]  open_cnt = '0;

    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;
    int tx_gap = 0;
    int rx_gap = 0;
    int long_hold = 0;
    int errors = 0;
    int cycle_cnt = 0;
    int bytes_queued = 0;
    int bytes_sent = 0;
    int strings_sent = 0;
    int chars_checked = 0;
    str_byte_t  next_byte;
    kana_char_t seen_want;

    always #5 clk = ~clk;

    function automatic logic [23:0] utf8_three(input logic [15:0] cp);
        return {4'hE, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
    endfunction

    function automatic logic [2:0] char_len(input logic [7:0] b);
        if (b < 8'hC0 || b >= 8'hF8)
        begin
            return 3'd1;
        end
        if (b >= 8'hF0)
        begin
            return 3'd4;
        end
        if (b >= 8'hE0)
        begin
            return 3'd3;
        end
        return 3'd2;
    endfunction

    function automatic logic [31:0] shift_kana(input logic [31:0] acc, input logic [2:0] cnt,
                                               input logic dir);
        logic [15:0] cp;
        if (cnt != 3'd3 || (acc[23:0] & 24'hF0C0C0) != 24'hE08080)
        begin
            return acc;
        end
        cp = {acc[19:16], acc[13:8], acc[5:0]};
        if (dir == DIR_HIRA_TO_KATA)
        begin
            if (cp < HIRA_LOW || cp > HIRA_HIGH)
            begin
                return acc;
            end
            cp = cp + KANA_SHIFT;
        end
        else
        begin
            if (cp < KATA_LOW || cp > KATA_HIGH)
            begin
                return acc;
            end
            cp = cp - KANA_SHIFT;
        end
        return {8'h00, utf8_three(cp)};
    endfunction

    task automatic group_and_convert(input logic [7:0] b, input logic last);
        logic [31:0] acc;
        logic [2:0]  cnt;
        kana_char_t  res;
        if (open_len == 3'd0)
        begin
            open_acc = '0;
            open_cnt = '0;
            open_len = char_len(b);
        end
        acc = {open_acc, b};
        cnt = open_cnt + 3'd1;
        if (cnt >= open_len)
        begin
            acc = shift_kana(acc, cnt, dir_now);
        end
        else if (!last)
        begin
            open_acc = acc[23:0];
            open_cnt = cnt;
            return;
        end
        res.word  = acc << (8 * (4 - cnt));
        res.count = cnt;
        res.eos   = last;
        kana_expected.push_back(res);
        open_acc = '0;
        open_len = '0;
        open_cnt = '0;
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic last);
        str_byte_t item;
        item.data = b;
        item.last = last;
        tx_bytes.push_back(item);
        bytes_queued++;
    endtask

    task automatic add_random_char(input bit is_last);
        logic [7:0]  seq [4];
        logic [15:0] cp;
        int          len;
        int          kind;
        kind = $urandom_range(0, 99);
        len = 1;
        for (int k = 0; k < 4; k++)
        begin
            seq[k] = 8'($urandom_range(8'h80, 8'hBF));
        end
        if (kind < 60)
        begin
            if (kind < 30)
            begin
                cp = 16'($urandom_range(HIRA_LOW, HIRA_HIGH));
            end
            else if (kind < 55)
            begin
                cp = 16'($urandom_range(KATA_LOW, KATA_HIGH));
            end
            else
            begin
                cp = 16'($urandom_range(16'h3000, 16'h31FF));
            end
            {seq[0], seq[1], seq[2]} = utf8_three(cp);
            len = 3;
        end
        else if (kind < 68)
        begin
            seq[0] = 8'($urandom_range(8'h00, 8'h7F));
        end
        else if (kind < 73)
        begin
            seq[0] = 8'($urandom_range(8'hC0, 8'hDF));
            len = 2;
        end
        else if (kind < 78)
        begin
            cp = 16'($urandom_range(0, 1) ? $urandom_range(16'hFF65, 16'hFF9F)
                                          : $urandom_range(16'h0800, 16'hFFFF));
            {seq[0], seq[1], seq[2]} = utf8_three(cp);
            len = 3;
        end
        else if (kind < 82)
        begin
            seq[0] = 8'($urandom_range(8'hF0, 8'hF7));
            len = 4;
        end
        else if (kind < 87)
        begin
            seq[0] = 8'((kind < 85) ? $urandom_range(8'h80, 8'hBF)
                                    : $urandom_range(8'hF8, 8'hFF));
        end
        else if (kind < 92)
        begin
            seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
            seq[1] = 8'($urandom_range(0, 255));
            seq[2] = 8'($urandom_range(0, 255));
            len = 3;
        end
        else if (kind < 95)
        begin
            cp = 16'($urandom_range(HIRA_LOW, KATA_HIGH));
            seq[0] = 8'hF0;
            seq[1] = {4'h8, cp[15:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
            len = 4;
        end
        else
        begin
            seq[0] = 8'($urandom_range(0, 255));
        end
        if (is_last && len > 1 && $urandom_range(0, 3) == 0)
        begin
            len = $urandom_range(1, len - 1);
        end
        for (int k = 0; k < len; k++)
        begin
            queue_byte(seq[k], is_last && (k == len - 1));
        end
    endtask

    task automatic add_random_string();
        int n_chars;
        n_chars = $urandom_range(1, 12);
        for (int i = 0; i < n_chars; i++)
        begin
            add_random_char(i == n_chars - 1);
        end
        strings_sent++;
    endtask

    task automatic write_direction(input logic d);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        dir_now = d;
        @(negedge clk);
    endtask

    task automatic drain();
        while (tx_bytes.size() != 0 || in_ch.valid || kana_expected.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_phase(input logic d, input bit tx_on, input bit rx_on,
                                input int hold);
        int target;
        write_direction(d);
        tx_idle = tx_on;
        rx_idle = rx_on;
        long_hold = hold;
        target = bytes_queued + PHASE_BYTES;
        while (bytes_queued < target)
        begin
            add_random_string();
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d bytes queued and %0d characters pending",
                     $time, tx_bytes.size(), kana_expected.size());
            $display("tb_utf8_kana_converter NOT OK");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid      <= 1'b0;
            in_ch.data_byte  <= 8'h00;
            in_ch.string_end <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                group_and_convert(in_ch.data_byte, in_ch.string_end);
                bytes_sent++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (tx_bytes.size() != 0)
                begin
                    next_byte = tx_bytes.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.data_byte  <= next_byte.data;
                    in_ch.string_end <= next_byte.last;
                    tx_gap = tx_idle ? $urandom_range(0, 10) : 0;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (kana_expected.size() == 0)
                begin
                    if (errors < 50)
                    begin
                        $display("%0t: unexpected transaction, expected none, got %h/%0d/%0b",
                                 $time, out_ch.char_bytes, out_ch.byte_count,
                                 out_ch.end_of_string);
                    end
                    errors++;
                end
                else
                begin
                    seen_want = kana_expected.pop_front();
                    if (out_ch.char_bytes !== seen_want.word)
                    begin
                        if (errors < 50)
                        begin
                            $display("%0t: char_bytes expected %h, got %h",
                                     $time, seen_want.word, out_ch.char_bytes);
                        end
                        errors++;
                    end
                    if (out_ch.byte_count !== seen_want.count)
                    begin
                        if (errors < 50)
                        begin
                            $display("%0t: byte_count expected %0d, got %0d",
                                     $time, seen_want.count, out_ch.byte_count);
                        end
                        errors++;
                    end
                    if (out_ch.end_of_string !== seen_want.eos)
                    begin
                        if (errors < 50)
                        begin
                            $display("%0t: end_of_string expected %0b, got %0b",
                                     $time, seen_want.eos, out_ch.end_of_string);
                        end
                        errors++;
                    end
                    chars_checked++;
                end
                rx_gap = rx_idle ? $urandom_range(0, 10) : 0;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                out_ch.ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_direction(DIR_HIRA_TO_KATA);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        queue_byte(8'hE3, 1'b0); queue_byte(8'h81, 1'b0); queue_byte(8'h80, 1'b0);
        queue_byte(8'hE3, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'h9F, 1'b0);
        queue_byte(8'hE3, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'hA0, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hC3, 1'b0); queue_byte(8'hA9, 1'b0);
        queue_byte(8'hF0, 1'b0); queue_byte(8'h83, 1'b0);
        queue_byte(8'h81, 1'b0); queue_byte(8'h80, 1'b0);
        queue_byte(8'hE3, 1'b0); queue_byte(8'h81, 1'b1);
        strings_sent++;
        drain();

        write_direction(DIR_KATA_TO_HIRA);
        queue_byte(8'hE3, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'hA0, 1'b0);
        queue_byte(8'hE3, 1'b0); queue_byte(8'h83, 1'b0); queue_byte(8'hBF, 1'b0);
        queue_byte(8'hE3, 1'b0); queue_byte(8'h41, 1'b0); queue_byte(8'h42, 1'b1);
        strings_sent++;
        drain();

        random_phase(DIR_KATA_TO_HIRA, 1'b1, 1'b1, 0);
        random_phase(DIR_HIRA_TO_KATA, 1'b1, 1'b1, 0);
        random_phase(DIR_HIRA_TO_KATA, 1'b0, 1'b1, LONG_HOLD);
        random_phase(DIR_KATA_TO_HIRA, 1'b0, 1'b0, 0);

        if (kana_expected.size() != 0)
        begin
            $display("%0t: %0d expected characters never arrived", $time, kana_expected.size());
            errors++;
        end
        $display("Sent %0d bytes in %0d strings and checked %0d characters.",
                 bytes_sent, strings_sent, chars_checked);
        $display("Both directions ran with idle gaps, a long output stall and back-to-back traffic.");
        if (errors == 0)
        begin
            $display("tb_utf8_kana_converter OK");
        end
        else
        begin
            $display("tb_utf8_kana_converter NOT OK");
        end
        $finish;
    end
endmodule
